// ===== src/snts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the SNTP server timestamper.
// Depends on nothing; every other file of the block uses it.
package snts_pkg;

  // Width of the time value inside the conversion datapath.
  localparam int unsigned TIME_CALC_W = 64;

  // Number of register stages in one time-to-NTP converter.
  localparam int unsigned CONV_STAGES = 6;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic {
    CMD_DISCIPLINE = 1'b0,
    CMD_REQUEST    = 1'b1
  } command_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STRATUM = 4'd0,
    CFG_REF_ID  = 4'd1
  } cfg_reg_e;

  localparam logic [7:0]  STRATUM_RESET = 8'd2;
  localparam logic [31:0] REF_ID_RESET  = 32'h564D5300;

  // Seconds between the NTP epoch (1900) and the Unix epoch (1970).
  localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;

  // One million is 2^6 * 15625: the low six bits are split off first.
  localparam int unsigned DIV_SHIFT = 6;
  localparam logic [13:0] DIV_ODD   = 14'd15625;

  // floor(2^58 / 15625); the quotient estimate is low by at most one.
  localparam logic [44:0] Q_MAGIC    = 45'd18446744073709;
  localparam logic [22:0] Q_MAGIC_HI = Q_MAGIC[44:22];
  localparam logic [21:0] Q_MAGIC_LO = Q_MAGIC[21:0];

  // ceil(2^66 / 10^6); exact for the fraction of any remainder below 10^6.
  localparam logic [46:0] FRAC_MAGIC    = 47'd73786976294839;
  localparam logic [22:0] FRAC_MAGIC_HI = FRAC_MAGIC[46:24];
  localparam logic [23:0] FRAC_MAGIC_LO = FRAC_MAGIC[23:0];

  typedef struct packed {
    logic [7:0]  poll;
    logic [31:0] orig_seconds;
    logic [31:0] orig_fraction;
  } meta_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic [31:0] fraction;
  } ntp_ts_t;

endpackage

// ===== src/snts_intf.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the SNTP server timestamper:
// request input, response output and configuration write. Uses snts_pkg.

interface snts_req_if #(
  parameter int unsigned OFFSET_WIDTH = 48,
  parameter int unsigned TIME_WIDTH   = 53
);
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [OFFSET_WIDTH-1:0] offset_error_us;
  logic [TIME_WIDTH-1:0]          raw_receive_us;
  logic [TIME_WIDTH-1:0]          raw_transmit_us;
  logic [7:0]                     client_poll;
  logic [31:0]                    client_tx_seconds;
  logic [31:0]                    client_tx_fraction;

  modport source (
    output valid, command, offset_error_us, raw_receive_us, raw_transmit_us,
           client_poll, client_tx_seconds, client_tx_fraction,
    input  ready
  );
  modport sink (
    input  valid, command, offset_error_us, raw_receive_us, raw_transmit_us,
           client_poll, client_tx_seconds, client_tx_fraction,
    output ready
  );
endinterface

interface snts_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echoed_poll;
  logic [31:0] originate_seconds;
  logic [31:0] originate_fraction;
  logic [31:0] receive_seconds;
  logic [31:0] receive_fraction;
  logic [31:0] transmit_seconds;
  logic [31:0] transmit_fraction;

  modport source (
    output valid, echoed_poll, originate_seconds, originate_fraction,
           receive_seconds, receive_fraction, transmit_seconds, transmit_fraction,
    input  ready
  );
  modport sink (
    input  valid, echoed_poll, originate_seconds, originate_fraction,
           receive_seconds, receive_fraction, transmit_seconds, transmit_fraction,
    output ready
  );
endinterface

interface snts_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [snts_pkg::CFG_INDEX_W-1:0]   index;
  logic [snts_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/sntp_server_timestamper.sv =====
`timescale 1ns / 1ps
// Top level of the SNTP server timestamper: input register, offset
// correction, two NTP converters and the response register.
// Depends on snts_pkg, snts_intf, snts_discipline and snts_ntp_conv.
//
//   Channel | Modport      | Moves                      | Notes
//   req_i   | sink         | discipline or client item  | command selects the kind
//   rsp_o   | source       | one timestamp response     | only for client requests
//   cfg_i   | sink         | register index and data    | always ready
//
// A client request is taken in every cycle while the response side keeps up
// and no discipline update is pending. Its response passes the input register,
// the correction register and the six converter stages, the last converter
// stage being the response register. A discipline request produces no
// response and holds the request input low while the offset register takes
// its new value. Reset is asynchronous and active low; it clears the offset
// and the valid bits and loads the configuration registers with their reset
// values. A stall on rsp_o backs up stage by stage, so empty stages keep
// filling and the input stays open until the pipe is full.
module sntp_server_timestamper #(
  parameter int unsigned OFFSET_WIDTH = 48,
  parameter int unsigned TIME_WIDTH   = 53
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  snts_cfg_if.sink   cfg_i,
  snts_req_if.sink   req_i,
  snts_rsp_if.source rsp_o
);
  import snts_pkg::*;

  // Stage 0 is the input register, stage 1 holds corrected times, stages
  // 2 to 7 are the converter registers; stage 7 is the response register.
  localparam int unsigned LAST  = CONV_STAGES + 1;
  localparam int unsigned SUM_W = ((TIME_WIDTH > OFFSET_WIDTH) ? TIME_WIDTH
                                                               : OFFSET_WIDTH) + 2;
  localparam logic [SUM_W-1:0] TMAX_EXT = {{(SUM_W-TIME_WIDTH){1'b0}},
                                           {TIME_WIDTH{1'b1}}};

  // Header fields written through the configuration channel.
  logic [7:0]  stratum_q;
  logic [31:0] ref_id_q;

  logic [LAST:0] v_q;
  logic [LAST:0] ld;

  command_e                       cmd_q;
  logic signed [OFFSET_WIDTH-1:0] meas_q;
  logic [TIME_WIDTH-1:0]          raw_rx_q, raw_tx_q;
  meta_t                          meta0_q;
  meta_t                          meta_q [1:LAST];

  logic [TIME_CALC_W-1:0] t_rx_q, t_tx_q;
  logic [TIME_WIDTH-1:0]  t_rx_d, t_tx_d;

  logic                           req_accept;
  logic                           disc_start;
  logic                           disc_busy;
  logic                           offset_busy;
  logic signed [OFFSET_WIDTH-1:0] offset;
  ntp_ts_t                        rx_ts, tx_ts;

  // Adds the signed offset to a raw time and clamps into the time range.
  function automatic logic [TIME_WIDTH-1:0] correct_time(
    input logic [TIME_WIDTH-1:0]          raw,
    input logic signed [OFFSET_WIDTH-1:0] off
  );
    logic signed [SUM_W-1:0] sum;
    logic [TIME_WIDTH-1:0]   res;
    sum = $signed({{(SUM_W-TIME_WIDTH){1'b0}}, raw})
        + $signed({{(SUM_W-OFFSET_WIDTH){off[OFFSET_WIDTH-1]}}, off});
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (sum > $signed(TMAX_EXT)) begin
      res = '1;
    end else begin
      res = sum[TIME_WIDTH-1:0];
    end
    return res;
  endfunction

  // Configuration writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stratum_q <= STRATUM_RESET;
      ref_id_q  <= REF_ID_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_STRATUM: stratum_q <= cfg_i.data[7:0];
        CFG_REF_ID:  ref_id_q  <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when it is empty or its content moves on.
  // A discipline request in stage 0 always leaves, since it goes to the
  // offset unit and not down the pipe.
  always_comb begin
    ld[LAST] = !v_q[LAST] || rsp_o.ready;
    for (int i = LAST - 1; i >= 1; i--) begin
      ld[i] = !v_q[i] || ld[i+1];
    end
    ld[0] = !v_q[0] || (cmd_q == CMD_DISCIPLINE) || ld[1];
  end

  // Requests behind a discipline request wait until the new offset is in.
  assign disc_start  = v_q[0] && (cmd_q == CMD_DISCIPLINE);
  assign disc_busy   = disc_start || offset_busy;
  assign req_i.ready = ld[0] && !disc_busy;
  assign req_accept  = req_i.valid && req_i.ready;

  snts_discipline #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_discipline (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (disc_start),
    .meas_i  (meas_q),
    .offset_o(offset),
    .busy_o  (offset_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= req_accept;
      end
      if (ld[1]) begin
        v_q[1] <= v_q[0] && (cmd_q == CMD_REQUEST);
      end
      for (int i = 2; i <= LAST; i++) begin
        if (ld[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      cmd_q                 <= command_e'(req_i.command);
      meas_q                <= req_i.offset_error_us;
      raw_rx_q              <= req_i.raw_receive_us;
      raw_tx_q              <= req_i.raw_transmit_us;
      meta0_q.poll          <= req_i.client_poll;
      meta0_q.orig_seconds  <= req_i.client_tx_seconds;
      meta0_q.orig_fraction <= req_i.client_tx_fraction;
    end
  end

  // Offset correction with clamping, registered into stage 1.
  assign t_rx_d = correct_time(raw_rx_q, offset);
  assign t_tx_d = correct_time(raw_tx_q, offset);

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      t_rx_q     <= TIME_CALC_W'(t_rx_d);
      t_tx_q     <= TIME_CALC_W'(t_tx_d);
      meta_q[1]  <= meta0_q;
    end
  end

  // Echoed fields ride along with the converter stages.
  always_ff @(posedge clk_i) begin
    for (int i = 2; i <= LAST; i++) begin
      if (ld[i]) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  snts_ntp_conv u_conv_rx (
    .clk_i (clk_i),
    .adv_i (ld[LAST:2]),
    .time_i(t_rx_q),
    .ts_o  (rx_ts)
  );

  snts_ntp_conv u_conv_tx (
    .clk_i (clk_i),
    .adv_i (ld[LAST:2]),
    .time_i(t_tx_q),
    .ts_o  (tx_ts)
  );

  // Response register outputs.
  assign rsp_o.valid              = v_q[LAST];
  assign rsp_o.echoed_poll        = meta_q[LAST].poll;
  assign rsp_o.originate_seconds  = meta_q[LAST].orig_seconds;
  assign rsp_o.originate_fraction = meta_q[LAST].orig_fraction;
  assign rsp_o.receive_seconds    = rx_ts.seconds;
  assign rsp_o.receive_fraction   = rx_ts.fraction;
  assign rsp_o.transmit_seconds   = tx_ts.seconds;
  assign rsp_o.transmit_fraction  = tx_ts.fraction;

endmodule

// ===== src/snts_discipline.sv =====
`timescale 1ns / 1ps
// Clock offset register and its slew update by one eighth of the error.
// Uses snts_pkg; instantiated by sntp_server_timestamper.
module snts_discipline #(
  parameter int unsigned OFFSET_WIDTH = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [OFFSET_WIDTH-1:0] meas_i,
  output logic signed [OFFSET_WIDTH-1:0] offset_o,
  output logic                           busy_o
);
  import snts_pkg::*;

  localparam int unsigned DW = OFFSET_WIDTH + 1;

  logic signed [OFFSET_WIDTH-1:0] offset_q, offset_d;
  logic signed [DW-1:0]           diff_q, diff_d;
  logic                           pending_q;
  logic                           round_up;
  logic signed [DW-1:0]           step;

  // First step: error between measurement and current offset, registered on start.
  assign diff_d = $signed({meas_i[OFFSET_WIDTH-1], meas_i})
                - $signed({offset_q[OFFSET_WIDTH-1], offset_q});

  // Second step: an arithmetic shift rounds toward minus infinity, so a
  // negative error with a nonzero remainder gets one added back.
  assign round_up = diff_q[DW-1] && (diff_q[2:0] != 3'd0);
  assign step     = diff_q >>> 3;
  assign offset_d = OFFSET_WIDTH'($signed({offset_q[OFFSET_WIDTH-1], offset_q})
                                  + step + $signed({{(DW-1){1'b0}}, round_up}));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      diff_q <= diff_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      offset_q  <= '0;
    end else begin
      pending_q <= start_i;
      if (pending_q) begin
        offset_q <= offset_d;
      end
    end
  end

  assign offset_o = offset_q;
  assign busy_o   = pending_q;

endmodule

// ===== src/snts_ntp_conv.sv =====
`timescale 1ns / 1ps
// Six-stage converter from Unix microseconds to NTP seconds and fraction,
// built from constant reciprocal multiplies. Uses snts_pkg.
module snts_ntp_conv (
  input  logic                                  clk_i,
  input  logic [snts_pkg::CONV_STAGES-1:0]      adv_i,
  input  logic [snts_pkg::TIME_CALC_W-1:0]      time_i,
  output snts_pkg::ntp_ts_t                     ts_o
);
  import snts_pkg::*;

  localparam int unsigned TP_W = TIME_CALC_W - DIV_SHIFT;
  localparam int unsigned TH_W = TP_W - 29;

  logic [TP_W-1:0] tp;
  logic [TH_W-1:0] th;
  logic [28:0]     tl;

  // Stage 1: partial products of the quotient estimate.
  logic [51:0] pp_hh_q, pp_lh_q;
  logic [50:0] pp_hl_q, pp_ll_q;
  logic [15:0] lo16_1_q;
  logic [5:0]  low6_1_q;
  // Stage 2: quotient estimate.
  logic [102:0] prod_sum;
  logic [31:0]  qest_q;
  logic [15:0]  lo16_2_q;
  logic [5:0]   low6_2_q;
  // Stage 3: remainder of the estimate.
  logic [29:0] qm;
  logic [15:0] rem_d, rem_q;
  logic [31:0] q3_q;
  logic [5:0]  low6_3_q;
  // Stage 4: corrected quotient and microsecond remainder.
  logic        corr;
  logic [13:0] rhi;
  logic [19:0] r_d, r_q;
  logic [31:0] sec_d, sec4_q;
  // Stage 5: partial products of the fraction.
  logic [42:0] pa_q;
  logic [43:0] pb_q;
  logic [31:0] sec5_q;
  // Stage 6: fraction.
  logic [66:0] frac_sum;
  ntp_ts_t     ts_q;

  assign tp = time_i[TIME_CALC_W-1:DIV_SHIFT];
  assign th = tp[TP_W-1:29];
  assign tl = tp[28:0];

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      pp_hh_q  <= 52'(th) * 52'(Q_MAGIC_HI);
      pp_hl_q  <= 51'(th) * 51'(Q_MAGIC_LO);
      pp_lh_q  <= 52'(tl) * 52'(Q_MAGIC_HI);
      pp_ll_q  <= 51'(tl) * 51'(Q_MAGIC_LO);
      lo16_1_q <= tp[15:0];
      low6_1_q <= time_i[DIV_SHIFT-1:0];
    end
  end

  assign prod_sum = (103'(pp_hh_q) << 51) + (103'(pp_hl_q) << 29)
                  + (103'(pp_lh_q) << 22) + 103'(pp_ll_q);

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      qest_q   <= prod_sum[89:58];
      lo16_2_q <= lo16_1_q;
      low6_2_q <= low6_1_q;
    end
  end

  // The true remainder is below twice the divisor, so 16 bits suffice.
  assign qm    = 30'(qest_q[15:0]) * 30'(DIV_ODD);
  assign rem_d = lo16_2_q - qm[15:0];

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      rem_q    <= rem_d;
      q3_q     <= qest_q;
      low6_3_q <= low6_2_q;
    end
  end

  assign corr  = (rem_q >= 16'(DIV_ODD));
  assign rhi   = corr ? 14'(rem_q - 16'(DIV_ODD)) : rem_q[13:0];
  assign r_d   = {rhi, low6_3_q};
  assign sec_d = q3_q + NTP_UNIX_DELTA + 32'(corr);

  always_ff @(posedge clk_i) begin
    if (adv_i[3]) begin
      r_q    <= r_d;
      sec4_q <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[4]) begin
      pa_q   <= 43'(r_q) * 43'(FRAC_MAGIC_HI);
      pb_q   <= 44'(r_q) * 44'(FRAC_MAGIC_LO);
      sec5_q <= sec4_q;
    end
  end

  assign frac_sum = (67'(pa_q) << 24) + 67'(pb_q);

  always_ff @(posedge clk_i) begin
    if (adv_i[5]) begin
      ts_q.seconds  <= sec5_q;
      ts_q.fraction <= frac_sum[65:34];
    end
  end

  assign ts_o = ts_q;

endmodule
